// ----- design/sws_pkg.sv -----
package sws_pkg;

   localparam int STAKE_W = 32;
   localparam int WINS_W  = 32;
   localparam int DRAW_W  = 16;
   localparam int SLOT_W  = 4;
   localparam int CHOSEN_W = 4;
   localparam int SCALED_W = STAKE_W + DRAW_W;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_SELECT = 2'd1;
   localparam logic [1:0] CMD_TOPUP  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_BADSLOT = 2'd3;

   // control from the sequencer to the scan unit
   typedef struct packed {
      logic clear;
      logic valid;
   } scan_ctl_type;

endpackage

// ----- design/sws_ram.sv -----
module sws_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/sws_acc.sv -----
module sws_acc #(
   parameter int IDX_W = 4,
   parameter int RS_W  = 52
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sws_pkg::scan_ctl_type          ctl,
   input  logic [IDX_W-1:0]               rd_idx,
   input  logic [sws_pkg::STAKE_W-1:0]    rd_stake,
   input  logic [sws_pkg::WINS_W-1:0]     rd_wins,
   input  logic [RS_W-1:0]                lhs,
   output logic [IDX_W-1:0]               pick_idx,
   output logic [sws_pkg::STAKE_W-1:0]    pick_stake,
   output logic [sws_pkg::WINS_W-1:0]     pick_wins
);

   // stage 1: scale the stake by 65535 as (s << 16) - s
   logic                            s1_valid_ff;
   logic [sws_pkg::SCALED_W-1:0]    s1_scaled_ff;
   logic [sws_pkg::STAKE_W-1:0]     s1_stake_ff;
   logic [sws_pkg::WINS_W-1:0]      s1_wins_ff;
   logic [IDX_W-1:0]                s1_idx_ff;
   logic [sws_pkg::SCALED_W-1:0]    s1_scaled_in;

   // stage 2: running scaled sum and compare
   logic [RS_W-1:0]                 rs_ff;
   logic [RS_W-1:0]                 rs_in;
   logic                            found_ff;
   logic                            hit;
   logic                            load;
   logic [IDX_W-1:0]                pick_idx_ff;
   logic [sws_pkg::STAKE_W-1:0]     pick_stake_ff;
   logic [sws_pkg::WINS_W-1:0]      pick_wins_ff;

   assign s1_scaled_in = {rd_stake, {sws_pkg::DRAW_W{1'b0}}}
                       - sws_pkg::SCALED_W'(rd_stake);

   assign rs_in = rs_ff + RS_W'(s1_scaled_ff);
   assign hit   = s1_valid_ff && !found_ff && (lhs <= rs_in);
   // entry 0 is the fallback, so latch it unless something already won
   assign load  = s1_valid_ff && !found_ff && (hit || (s1_idx_ff == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         rs_ff       <= '0;
      end else if (ctl.clear) begin
         s1_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         rs_ff       <= '0;
      end else begin
         s1_valid_ff <= ctl.valid;
         if (s1_valid_ff) begin
            rs_ff <= rs_in;
         end
         if (hit) begin
            found_ff <= 1'b1;
         end
      end
      s1_scaled_ff <= s1_scaled_in;
      s1_stake_ff  <= rd_stake;
      s1_wins_ff   <= rd_wins;
      s1_idx_ff    <= rd_idx;
      if (load) begin
         pick_idx_ff   <= s1_idx_ff;
         pick_stake_ff <= s1_stake_ff;
         pick_wins_ff  <= s1_wins_ff;
      end
   end

   assign pick_idx   = pick_idx_ff;
   assign pick_stake = pick_stake_ff;
   assign pick_wins  = pick_wins_ff;

endmodule

// ----- design/stake_weighted_selector_top.sv -----
// Channel   | Ports                                           | Direction | Handshake
// ----------+-------------------------------------------------+-----------+------------------
// request   | req_command, req_amount, req_draw, req_slot     | in        | start & !busy
// response  | rsp_status, rsp_chosen, rsp_chosen_stake, rsp_wins | out    | rsp_valid, 1 cycle
//
// Add answers in the cycle after the word is taken. Top-up reads the table,
// adds with saturation and writes back. Select issues one table read per
// entry through the entry table's read port, feeding the scale/accumulate/
// compare unit, then drains it and writes back the win count. Error cases
// answer in the cycle after the word is taken. Reset clears the entry count,
// the stake total and the sequencer; the table contents stay undefined until
// added. The receiver cannot stall: each response word is shown for exactly
// one cycle.
module stake_weighted_selector_top #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_command,
   input  logic [sws_pkg::STAKE_W-1:0]     req_amount,
   input  logic [sws_pkg::DRAW_W-1:0]      req_draw,
   input  logic [sws_pkg::SLOT_W-1:0]      req_slot,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [sws_pkg::CHOSEN_W-1:0]    rsp_chosen,
   output logic [sws_pkg::STAKE_W-1:0]     rsp_chosen_stake,
   output logic [sws_pkg::WINS_W-1:0]      rsp_wins
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > sws_pkg::SLOT_W) ? CNT_W : sws_pkg::SLOT_W;
   // a sum of MAX_ENTRIES full stakes fits here
   localparam int TOT_W = sws_pkg::STAKE_W + $clog2(MAX_ENTRIES);
   localparam int RS_W  = TOT_W + sws_pkg::DRAW_W;
   localparam int ENT_W = sws_pkg::WINS_W + sws_pkg::STAKE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_WIN,
      S_TOP_SUM,
      S_TOP_WR
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [TOT_W-1:0]              total_ff, total_in;
   logic [IDX_W-1:0]              addr_ff, addr_in;
   logic [RS_W-1:0]               lhs_ff, lhs_in;
   logic                          drain_ff, drain_in;
   logic [sws_pkg::STAKE_W-1:0]   added_ff, added_in;
   logic                          rd_valid_ff;
   logic [IDX_W-1:0]              rd_idx_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [sws_pkg::CHOSEN_W-1:0]  rsp_chosen_ff, rsp_chosen_in;
   logic [sws_pkg::STAKE_W-1:0]   rsp_stake_ff, rsp_stake_in;
   logic [sws_pkg::WINS_W-1:0]    rsp_wins_ff, rsp_wins_in;

   // entry table: {wins, stake}
   logic                          ram_we;
   logic [IDX_W-1:0]              ram_waddr;
   logic [ENT_W-1:0]              ram_wdata;
   logic [IDX_W-1:0]              ram_raddr;
   logic [ENT_W-1:0]              ram_rdata;
   logic [sws_pkg::STAKE_W-1:0]   rd_stake;
   logic [sws_pkg::WINS_W-1:0]    rd_wins;

   sws_pkg::scan_ctl_type         scan_ctl;
   logic [IDX_W-1:0]              pick_idx;
   logic [sws_pkg::STAKE_W-1:0]   pick_stake;
   logic [sws_pkg::WINS_W-1:0]    pick_wins;

   logic                          accept;
   logic [CMP_W-1:0]              slot_ext;
   logic [CMP_W-1:0]              count_ext;
   logic [CMP_W-1:0]              pick_ext;
   logic [CMP_W-1:0]              rslot_ext;
   logic [CNT_W:0]                addr_next_ext;
   logic                          scan_last;
   logic [sws_pkg::STAKE_W:0]     topup_sum;

   assign accept        = start && !busy;
   assign slot_ext      = CMP_W'(req_slot);
   assign count_ext     = CMP_W'(count_ff);
   assign pick_ext      = CMP_W'(pick_idx);
   assign rslot_ext     = CMP_W'(ram_raddr);
   assign addr_next_ext = (CNT_W + 1)'(addr_ff) + 1'b1;
   assign scan_last     = (addr_next_ext == (CNT_W + 1)'(count_ff));
   assign rd_stake      = ram_rdata[sws_pkg::STAKE_W-1:0];
   assign rd_wins       = ram_rdata[ENT_W-1:sws_pkg::STAKE_W];
   // the amount is only needed in the cycle after accept; hold it in added_ff
   assign topup_sum     = {1'b0, rd_stake} + {1'b0, added_ff};

   sws_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign scan_ctl.clear = accept && (req_command == sws_pkg::CMD_SELECT);
   assign scan_ctl.valid = rd_valid_ff;

   sws_acc #(
      .IDX_W (IDX_W),
      .RS_W  (RS_W)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .rd_idx     (rd_idx_ff),
      .rd_stake   (rd_stake),
      .rd_wins    (rd_wins),
      .lhs        (lhs_ff),
      .pick_idx   (pick_idx),
      .pick_stake (pick_stake),
      .pick_wins  (pick_wins)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      addr_in       = addr_ff;
      lhs_in        = lhs_ff;
      drain_in      = drain_ff;
      added_in      = added_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_stake_in  = rsp_stake_ff;
      rsp_wins_in   = rsp_wins_ff;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = {rsp_wins_ff, rsp_stake_ff};
      ram_raddr     = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            // read the addressed slot early so top-up data is ready next cycle
            ram_raddr = slot_ext[IDX_W-1:0];
            if (start) begin
               unique case (req_command)
                  sws_pkg::CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                        rsp_status_in = sws_pkg::ST_FULL;
                        rsp_chosen_in = '0;
                        rsp_stake_in  = '0;
                        rsp_wins_in   = '0;
                     end else begin
                        ram_we        = 1'b1;
                        ram_waddr     = count_ff[IDX_W-1:0];
                        ram_wdata     = {{sws_pkg::WINS_W{1'b0}}, req_amount};
                        count_in      = count_ff + 1'b1;
                        total_in      = total_ff + TOT_W'(req_amount);
                        rsp_status_in = sws_pkg::ST_OK;
                        rsp_chosen_in = count_ext[sws_pkg::CHOSEN_W-1:0];
                        rsp_stake_in  = req_amount;
                        rsp_wins_in   = '0;
                     end
                  end
                  sws_pkg::CMD_SELECT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = sws_pkg::ST_EMPTY;
                        rsp_chosen_in = '0;
                        rsp_stake_in  = '0;
                        rsp_wins_in   = '0;
                     end else begin
                        lhs_in   = RS_W'(req_draw) * RS_W'(total_ff);
                        addr_in  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  sws_pkg::CMD_TOPUP: begin
                     if (slot_ext >= count_ext) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = sws_pkg::ST_BADSLOT;
                        rsp_chosen_in = '0;
                        rsp_stake_in  = '0;
                        rsp_wins_in   = '0;
                     end else begin
                        addr_in  = slot_ext[IDX_W-1:0];
                        added_in = req_amount;
                        state_in = S_TOP_SUM;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = sws_pkg::ST_BADSLOT;
                     rsp_chosen_in = '0;
                     rsp_stake_in  = '0;
                     rsp_wins_in   = '0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // issue one table read per cycle, in entry order
            if (scan_last) begin
               drain_in = 1'b0;
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // let the last read pass both stages of the scan unit
            if (drain_ff) begin
               state_in = S_WIN;
            end else begin
               drain_in = 1'b1;
            end
         end
         S_WIN: begin
            ram_we        = 1'b1;
            ram_waddr     = pick_idx;
            rsp_valid_in  = 1'b1;
            rsp_status_in = sws_pkg::ST_OK;
            rsp_chosen_in = pick_ext[sws_pkg::CHOSEN_W-1:0];
            rsp_stake_in  = pick_stake;
            rsp_wins_in   = (pick_wins == '1) ? pick_wins : pick_wins + 1'b1;
            ram_wdata     = {rsp_wins_in, pick_stake};
            state_in      = S_WIN == state_ff ? S_IDLE : state_ff;
         end
         S_TOP_SUM: begin
            // saturate the stake; the total grows by what was really added
            rsp_chosen_in = CMP_W'(addr_ff) == rslot_ext ?
                            rslot_ext[sws_pkg::CHOSEN_W-1:0] : '0;
            rsp_wins_in   = rd_wins;
            if (topup_sum[sws_pkg::STAKE_W]) begin
               rsp_stake_in = '1;
               added_in     = ~rd_stake;
            end else begin
               rsp_stake_in = topup_sum[sws_pkg::STAKE_W-1:0];
            end
            state_in = S_TOP_WR;
         end
         S_TOP_WR: begin
            ram_we        = 1'b1;
            ram_waddr     = addr_ff;
            ram_wdata     = {rsp_wins_ff, rsp_stake_ff};
            total_in      = total_ff + TOT_W'(added_ff);
            rsp_valid_in  = 1'b1;
            rsp_status_in = sws_pkg::ST_OK;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         drain_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= (state_ff == S_SCAN);
         drain_ff     <= drain_in;
      end
      addr_ff       <= addr_in;
      lhs_ff        <= lhs_in;
      added_ff      <= added_in;
      rd_idx_ff     <= addr_ff;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_stake_ff  <= rsp_stake_in;
      rsp_wins_ff   <= rsp_wins_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen       = rsp_chosen_ff;
   assign rsp_chosen_stake = rsp_stake_ff;
   assign rsp_wins         = rsp_wins_ff;

endmodule
